@@ rtl/rrqs_pkg.sv @@
// Shared types and constants of the round-robin quantum scheduler.
`default_nettype none

package rrqs_pkg;

  localparam int MAX_PROCESSES_DEF = 16;
  localparam int ID_W = 8;
  localparam int TIME_W = 16;
  localparam logic [TIME_W-1:0] QUANTUM_RESET = 16'd3;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_RUN    = 1'b1;

  localparam logic [1:0] ST_SERVED   = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   proc_id;
    logic [TIME_W-1:0] burst_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   served_id;
    logic [TIME_W-1:0] time_left;
    logic [TIME_W-1:0] time_used;
    logic              completed;
    logic              last;
  } out_item_t;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] executed;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SERVE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/rrqs_update.sv @@
// Per-entry update: quantum off the remaining time, quantum onto the executed time.
`default_nettype none

module rrqs_update (
  input  rrqs_pkg::entry_t               cur,
  input  logic [rrqs_pkg::TIME_W-1:0]    quantum,
  output rrqs_pkg::entry_t               upd,
  output logic                           done
);
  import rrqs_pkg::*;

  logic [TIME_W:0] exe_sum;

  always_comb begin
    exe_sum       = {1'b0, cur.executed} + {1'b0, quantum};
    upd.id        = cur.id;
    upd.remaining = (cur.remaining > quantum) ? cur.remaining - quantum : '0;
    upd.executed  = exe_sum[TIME_W] ? '1 : exe_sum[TIME_W-1:0];
    done          = (upd.remaining == '0);
  end

endmodule

`default_nettype wire

@@ rtl/round_robin_quantum_scheduler_top.sv @@
// Top level: process table memory, run sequencer and output register.
//
//   channel   signals                              direction
//   in        in_valid, in_stall, in_item          item in
//   out       out_valid, out_stall, out_item       result out
//   config    quantum_we, quantum_wdata            register write
//
// Insert: one result. Run on an empty table: one result.
// Run: the accept, then for each stored entry a memory read (S_READ), then serve
// and write back (S_SERVE); the loop is unpipelined, with a registered memory read.
// Reset (rst, synchronous) empties the table and sets quantum to 3; no clearing pass.
// A stalled output holds the sequencer on its current entry; input stalls until idle with the output free.
`default_nettype none

module round_robin_quantum_scheduler_top #(
  parameter int MAX_PROCESSES = rrqs_pkg::MAX_PROCESSES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rrqs_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rrqs_pkg::out_item_t          out_item,
  input  logic                         quantum_we,
  input  logic [rrqs_pkg::TIME_W-1:0]  quantum_wdata
);
  import rrqs_pkg::*;

  localparam int AW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CW = $clog2(MAX_PROCESSES + 1);

  entry_t table_mem [MAX_PROCESSES];

  state_t            state, state_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     kept;
  logic [TIME_W-1:0] quantum;
  entry_t            rd_q;

  logic              out_free;
  logic              accept;
  logic              full;
  logic              last_entry;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic              out_load;
  out_item_t         res;

  entry_t            upd;
  logic              upd_done;

  rrqs_update u_update (
    .cur     (rd_q),
    .quantum (quantum),
    .upd     (upd),
    .done    (upd_done)
  );

  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = !((state == S_IDLE) && out_free);
  assign accept     = in_valid && !in_stall;
  assign full       = (count == CW'(MAX_PROCESSES));
  assign last_entry = (idx == count - CW'(1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (in_item.kind == KIND_RUN) && (count != '0)) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_SERVE;
      S_SERVE: begin
        if (out_free) begin
          state_next = last_entry ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    mem_we              = 1'b0;
    mem_re              = 1'b0;
    mem_waddr           = count[AW-1:0];
    mem_wdata.id        = in_item.proc_id;
    mem_wdata.remaining = in_item.burst_time;
    mem_wdata.executed  = '0;
    out_load            = 1'b0;
    res                 = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          res.last = 1'b1;
          if (in_item.kind == KIND_INSERT) begin
            res.served_id = in_item.proc_id;
            res.time_left = in_item.burst_time;
            if (full) begin
              res.status = ST_FULL;
            end else begin
              res.status = ST_INSERTED;
              mem_we     = 1'b1;
            end
          end else if (count == '0) begin
            res.status = ST_EMPTY;
          end else begin
            out_load = 1'b0;
          end
        end
      end
      S_READ: mem_re = 1'b1;
      S_SERVE: begin
        if (out_free) begin
          out_load      = 1'b1;
          res.status    = ST_SERVED;
          res.served_id = upd.id;
          res.time_left = upd.remaining;
          res.time_used = upd.executed;
          res.completed = upd_done;
          res.last      = last_entry;
          // survivors are packed toward the head; kept never passes idx
          if (!upd_done) begin
            mem_we    = 1'b1;
            mem_waddr = kept[AW-1:0];
            mem_wdata = upd;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= table_mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      idx     <= '0;
      kept    <= '0;
      quantum <= QUANTUM_RESET;
    end else begin
      state <= state_next;
      if (quantum_we) begin
        quantum <= quantum_wdata;
      end
      if (state == S_IDLE) begin
        idx  <= '0;
        kept <= '0;
        if (mem_we) begin
          count <= count + CW'(1);
        end
      end else if ((state == S_SERVE) && out_free) begin
        idx  <= idx + CW'(1);
        kept <= kept + CW'(!upd_done);
        if (last_entry) begin
          count <= kept + CW'(!upd_done);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire
